// ----- rtl/core/ntc_pkg.sv -----
// Shared types, constants and the finger cost function of the symbol child table.
package ntc_pkg;

  localparam int ENTRIES_DEF     = 16;
  localparam int SYMBOL_BITS_DEF = 32;
  localparam int WORD_W          = 16;
  localparam int KEY_W           = 32;
  localparam int SCORE_W         = 6;
  localparam int FINGERS         = 5;

  localparam logic [SCORE_W-1:0] THRESH_RESET = 6'd5;
  // Larger than any real score (max 55) and never below a 6-bit threshold.
  localparam logic [SCORE_W-1:0] SCORE_NONE   = 6'd63;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  localparam logic [1:0] CMD_ADD     = 2'd0;
  localparam logic [1:0] CMD_REMOVE  = 2'd1;
  localparam logic [1:0] CMD_PRESENT = 2'd2;
  localparam logic [1:0] CMD_LOOKUP  = 2'd3;

  typedef struct packed {
    logic [1:0]        command;
    logic [KEY_W-1:0]  symbol_key;
    logic [WORD_W-1:0] word_id;
  } in_req_t;

  typedef struct packed {
    logic               found;
    logic [3:0]         slot_index;
    logic [WORD_W-1:0]  word_out;
    logic [KEY_W-1:0]   matched_symbol;
    logic [SCORE_W-1:0] match_score;
    logic [4:0]         entry_count;
    logic               status;
  } out_rsp_t;

  typedef struct packed {
    logic               exact;
    logic [SCORE_W-1:0] score;
  } score_t;

  // Cost of one finger: 11, 4 or 2 for a difference of 3, 2 or 1.
  function automatic logic [3:0] finger_cost(input logic [1:0] a, input logic [1:0] b);
    logic [1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    unique case (d)
      2'd3:    finger_cost = 4'd11;
      2'd2:    finger_cost = 4'd4;
      2'd1:    finger_cost = 4'd2;
      default: finger_cost = 4'd0;
    endcase
  endfunction

endpackage

// ----- rtl/core/ntc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ntc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/ntc_score.sv -----
// Score unit: exact compare and finger distance of one stored symbol.
module ntc_score import ntc_pkg::*; #(
  parameter int SYM_W = 32
) (
  input  logic [SYM_W-1:0] key,
  input  logic [SYM_W-1:0] entry_sym,
  output score_t           result
);

  logic [SCORE_W-1:0] sum;

  always_comb begin
    sum = '0;
    for (int f = 0; f < FINGERS; f++) begin
      sum = sum + SCORE_W'(finger_cost(key[2*f +: 2], entry_sym[2*f +: 2]));
    end
    result.exact = (key == entry_sym);
    result.score = sum;
  end

endmodule

// ----- rtl/core/nearest_symbol_child_table.sv -----
// Ordered symbol/word table with add, remove, presence test and nearest lookup.
//
// The block keeps up to ENTRIES symbol/word pairs in insertion order in one RAM
// and handles one command (a request) at a time. Every command first scans the
// held entries through a single score unit, one entry per cycle, recording the
// first exact match and the first entry with the least finger score. A request
// passes through idle, where it is taken, the scan (one read per entry, then the
// registered read data and a step to close the scan), execute, and posting of
// the result. A remove also copies the tail down through the same RAM port to
// close the gap before posting. Posting waits while the previous result still
// sits unread in the output register. The input is ready only while the
// sequencer is idle; a finished result waits in the output register, so the next
// request can be taken before the previous one is read.
// The match threshold is written through cfg_wr_en/cfg_wr_data and resets to 5.
// The user must write it only while idle; the block itself does not enforce this.
// The RAM contents are not cleared; only entries that hold data are ever read.
module nearest_symbol_child_table import ntc_pkg::*; #(
  parameter int ENTRIES     = ENTRIES_DEF,
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_req_t            in_req,
  output logic               out_valid,
  input  logic               out_ready,
  output out_rsp_t           out_rsp,
  input  logic               cfg_wr_en,
  input  logic [SCORE_W-1:0] cfg_wr_data
);

  // Stored symbol width: the key port carries at most 32 bits.
  localparam int SW = (SYMBOL_BITS < KEY_W) ? SYMBOL_BITS : KEY_W;
  localparam int DW = SW + WORD_W;
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_EXEC, S_SHIFT, S_RESP} state_t;

  state_t             state_r, state_nxt;
  logic [1:0]         cmd_r, cmd_nxt;
  logic [SW-1:0]      key_r, key_nxt;
  logic [WORD_W-1:0]  wid_r, wid_nxt;
  logic [SCORE_W-1:0] thr_r, thr_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      scan_r, scan_nxt;
  logic               ev_vld_r, ev_vld_nxt;
  logic [IW-1:0]      ev_idx_r, ev_idx_nxt;
  logic               hit_r, hit_nxt;
  logic [IW-1:0]      hit_idx_r, hit_idx_nxt;
  logic [SW-1:0]      hit_sym_r, hit_sym_nxt;
  logic [WORD_W-1:0]  hit_word_r, hit_word_nxt;
  logic [SCORE_W-1:0] best_r, best_nxt;
  logic [IW-1:0]      best_idx_r, best_idx_nxt;
  logic [SW-1:0]      best_sym_r, best_sym_nxt;
  logic [WORD_W-1:0]  best_word_r, best_word_nxt;
  logic [CW-1:0]      sh_r, sh_nxt;
  logic               sh_vld_r, sh_vld_nxt;
  logic [IW-1:0]      sh_wa_r, sh_wa_nxt;
  out_rsp_t           rsp_r, rsp_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_rsp_t           out_rsp_r, out_rsp_nxt;

  logic          wr_en, rd_en;
  logic [IW-1:0] wr_addr, rd_addr;
  logic [DW-1:0] wr_data, rd_data;
  logic [SW-1:0] rd_sym;
  logic [WORD_W-1:0] rd_word;
  score_t        sc;
  logic          issue;
  logic [WORD_W-1:0] upd_word;

  assign rd_sym  = rd_data[DW-1:WORD_W];
  assign rd_word = rd_data[WORD_W-1:0];

  ntc_ram #(
    .WIDTH (DW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ntc_score #(
    .SYM_W (SW)
  ) u_score (
    .key       (key_r),
    .entry_sym (rd_sym),
    .result    (sc)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;
  assign upd_word  = (wid_r != '0) ? wid_r : hit_word_r;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    wid_nxt       = wid_r;
    thr_nxt       = thr_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    ev_vld_nxt    = 1'b0;
    ev_idx_nxt    = ev_idx_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_sym_nxt   = hit_sym_r;
    hit_word_nxt  = hit_word_r;
    best_nxt      = best_r;
    best_idx_nxt  = best_idx_r;
    best_sym_nxt  = best_sym_r;
    best_word_nxt = best_word_r;
    sh_nxt        = sh_r;
    sh_vld_nxt    = 1'b0;
    sh_wa_nxt     = sh_wa_r;
    rsp_nxt       = rsp_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_rsp_nxt   = out_rsp_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    issue         = 1'b0;

    if (cfg_wr_en) begin
      thr_nxt = cfg_wr_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_req.command;
          key_nxt   = in_req.symbol_key[SW-1:0];
          wid_nxt   = in_req.word_id;
          scan_nxt  = '0;
          hit_nxt   = 1'b0;
          best_nxt  = SCORE_NONE;
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        // Issue one read per cycle; the score unit sees its data in the next cycle.
        issue      = (scan_r < count_r);
        rd_en      = issue;
        rd_addr    = scan_r[IW-1:0];
        ev_vld_nxt = issue;
        ev_idx_nxt = scan_r[IW-1:0];
        if (issue) begin
          scan_nxt = scan_r + CW'(1);
        end
        if (ev_vld_r) begin
          if (sc.exact && !hit_r) begin
            hit_nxt      = 1'b1;
            hit_idx_nxt  = ev_idx_r;
            hit_sym_nxt  = rd_sym;
            hit_word_nxt = rd_word;
          end
          if (sc.score < best_r) begin
            best_nxt      = sc.score;
            best_idx_nxt  = ev_idx_r;
            best_sym_nxt  = rd_sym;
            best_word_nxt = rd_word;
          end
        end
        if (!issue && !ev_vld_r) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        rsp_nxt        = '0;
        rsp_nxt.status = STATUS_OK;
        state_nxt      = S_RESP;
        unique case (cmd_r)
          CMD_ADD: begin
            if (hit_r) begin
              rsp_nxt.found          = 1'b1;
              rsp_nxt.slot_index     = 4'(hit_idx_r);
              rsp_nxt.word_out       = upd_word;
              rsp_nxt.matched_symbol = KEY_W'(hit_sym_r);
              wr_en   = (wid_r != '0);
              wr_addr = hit_idx_r;
              wr_data = {hit_sym_r, wid_r};
            end else if (count_r == CW'(ENTRIES)) begin
              rsp_nxt.status = STATUS_FULL;
            end else begin
              rsp_nxt.slot_index     = 4'(count_r);
              rsp_nxt.word_out       = wid_r;
              rsp_nxt.matched_symbol = KEY_W'(key_r);
              wr_en     = 1'b1;
              wr_addr   = count_r[IW-1:0];
              wr_data   = {key_r, wid_r};
              count_nxt = count_r + CW'(1);
            end
          end
          CMD_REMOVE: begin
            if (hit_r) begin
              rsp_nxt.found          = 1'b1;
              rsp_nxt.slot_index     = 4'(hit_idx_r);
              rsp_nxt.word_out       = hit_word_r;
              rsp_nxt.matched_symbol = KEY_W'(hit_sym_r);
              // The count drops now; the copy reads entries up to the new count.
              count_nxt = count_r - CW'(1);
              sh_nxt    = CW'(hit_idx_r) + CW'(1);
              state_nxt = S_SHIFT;
            end
          end
          CMD_PRESENT: begin
            if (hit_r) begin
              rsp_nxt.found          = 1'b1;
              rsp_nxt.slot_index     = 4'(hit_idx_r);
              rsp_nxt.word_out       = hit_word_r;
              rsp_nxt.matched_symbol = KEY_W'(hit_sym_r);
            end
          end
          CMD_LOOKUP: begin
            if (hit_r) begin
              rsp_nxt.found          = 1'b1;
              rsp_nxt.slot_index     = 4'(hit_idx_r);
              rsp_nxt.word_out       = hit_word_r;
              rsp_nxt.matched_symbol = KEY_W'(hit_sym_r);
            end else if (best_r < thr_r) begin
              rsp_nxt.found          = 1'b1;
              rsp_nxt.slot_index     = 4'(best_idx_r);
              rsp_nxt.word_out       = best_word_r;
              rsp_nxt.matched_symbol = KEY_W'(best_sym_r);
              rsp_nxt.match_score    = best_r;
            end
          end
          default: begin
          end
        endcase
        rsp_nxt.entry_count = 5'(count_nxt);
      end

      S_SHIFT: begin
        // Read entry j+1, write it to j in the following cycle.
        issue      = (sh_r <= count_r);
        rd_en      = issue;
        rd_addr    = sh_r[IW-1:0];
        sh_vld_nxt = issue;
        sh_wa_nxt  = IW'(sh_r - CW'(1));
        if (issue) begin
          sh_nxt = sh_r + CW'(1);
        end
        wr_en   = sh_vld_r;
        wr_addr = sh_wa_r;
        wr_data = rd_data;
        if (!issue && !sh_vld_r) begin
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = rsp_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thr_r       <= THRESH_RESET;
      count_r     <= '0;
      ev_vld_r    <= 1'b0;
      sh_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      thr_r       <= thr_nxt;
      count_r     <= count_nxt;
      ev_vld_r    <= ev_vld_nxt;
      sh_vld_r    <= sh_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r       <= cmd_nxt;
    key_r       <= key_nxt;
    wid_r       <= wid_nxt;
    scan_r      <= scan_nxt;
    ev_idx_r    <= ev_idx_nxt;
    hit_r       <= hit_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_sym_r   <= hit_sym_nxt;
    hit_word_r  <= hit_word_nxt;
    best_r      <= best_nxt;
    best_idx_r  <= best_idx_nxt;
    best_sym_r  <= best_sym_nxt;
    best_word_r <= best_word_nxt;
    sh_r        <= sh_nxt;
    sh_wa_r     <= sh_wa_nxt;
    rsp_r       <= rsp_nxt;
    out_rsp_r   <= out_rsp_nxt;
  end

`ifndef SYNTH
  // The entry count never exceeds the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES))
    else $error("entry count above table size");

  // The table RAM is only written while executing or closing a gap.
  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_EXEC || state_r == S_SHIFT))
    else $error("table write outside execute or shift");

  // A result without a match carries no score.
  a_nomatch_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rsp_r.found) |-> out_rsp_r.match_score == '0)
    else $error("unmatched result carries a score");

  // An accepted request always starts with a scan of the table.
  a_start_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == S_SCAN)
    else $error("request accepted without a scan");
`endif

endmodule
